### hdl/rmps_pkg.sv
`timescale 1ns / 1ps
package rmps_pkg;

  localparam int PIXEL_BITS = 24;
  localparam int CFG_SIZE_BITS = 9;
  localparam int CFG_CENTER_BITS = 8;
  localparam int CFG_DATA_BITS = 9;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_CENTER_X     = 2'd2,
    CFG_CENTER_Y     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                         operation;
    logic signed [PIXEL_BITS-1:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] value;
    logic                  last;
  } out_word_t;

  typedef struct packed {
    logic [CFG_SIZE_BITS-1:0]   image_width;
    logic [CFG_SIZE_BITS-1:0]   image_height;
    logic [CFG_CENTER_BITS-1:0] center_x;
    logic [CFG_CENTER_BITS-1:0] center_y;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_MULX,
    F_MULY,
    F_SQRT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EXEC,
    B_CLEAR
  } back_state_t;

endpackage

### hdl/rmps_queue.sv
`timescale 1ns / 1ps
module rmps_queue import rmps_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/rmps_front.sv
`timescale 1ns / 1ps
module rmps_front import rmps_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int PROFILE_BINS = 2048,
  parameter int IB           = 16,
  parameter int BB           = 11,
  parameter int QW           = 53
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  in_word_t      in_word,
  input  cfg_regs_t     cfg,
  output logic          q_push,
  input  logic          q_full,
  output logic [QW-1:0] q_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int AB    = (IB > CFG_CENTER_BITS) ? IB : CFG_CENTER_BITS;
  localparam int SQB   = 2 * AB;
  localparam int RB    = AB + 4;
  localparam int VB    = 2 * RB;
  localparam int SW    = $clog2(RB + 1);

  front_state_t state_r, state_nxt;

  logic [CW-1:0] load_cnt_r, drain_cnt_r;
  logic          full_r;
  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;
  logic [CW-1:0] size;
  logic [CW-1:0] cnt_sel;
  logic [IB-1:0] idx;
  logic          accept, take, is_fetch, fetch_last;

  logic                         op_r, last_r;
  logic signed [PIXEL_BITS-1:0] pix_r;
  logic [IB-1:0]                idx_r, quo_r;
  logic [XW-1:0]                rem_r, w_r;
  logic [CFG_CENTER_BITS-1:0]   cx_r, cy_r;
  logic [SW-1:0]                step_r;
  logic [SQB-1:0]               sq_r;
  logic [VB-1:0]                v_r;
  logic [RB+1:0]                sqrem_r;
  logic [RB-1:0]                root_r;

  logic [XW:0]    div_sh;
  logic [XW-1:0]  div_rem;
  logic [IB-1:0]  div_quo;
  logic [AB-1:0]  x_ext, y_ext, cx_ext, cy_ext, ax, ay;
  logic [SQB-1:0] sqy;
  logic [SQB:0]   r2;
  logic [RB+3:0]  sq_try, sq_trial;
  logic [RB:0]    k_full;
  logic [BB-1:0]  bin;

  // frame size from the registers, saturated
  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = XW'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      eff_w = XW'(MAX_WIDTH);
    end else begin
      eff_w = XW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      eff_h = YW'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      eff_h = YW'(MAX_HEIGHT);
    end else begin
      eff_h = YW'(cfg.image_height);
    end
    size = CW'(eff_w) * CW'(eff_h);
  end

  assign in_full    = (state_r != F_IDLE);
  assign accept     = in_push && !in_full;
  assign is_fetch   = (in_word.operation == OP_FETCH);
  assign take       = accept && (is_fetch ? full_r : !full_r);
  assign cnt_sel    = is_fetch ? drain_cnt_r : load_cnt_r;
  assign idx        = (32'(cnt_sel) >= DEPTH) ? IB'(DEPTH - 1) : IB'(cnt_sel);
  assign fetch_last = ((drain_cnt_r + CW'(1)) >= size);

  // restoring divide step: idx / width
  always_comb begin
    div_sh = {rem_r, quo_r[IB-1]};
    if (div_sh >= {1'b0, w_r}) begin
      div_rem = XW'(div_sh - {1'b0, w_r});
      div_quo = {quo_r[IB-2:0], 1'b1};
    end else begin
      div_rem = div_sh[XW-1:0];
      div_quo = {quo_r[IB-2:0], 1'b0};
    end
  end

  // distance terms
  always_comb begin
    x_ext  = AB'(rem_r);
    y_ext  = AB'(quo_r);
    cx_ext = AB'(cx_r);
    cy_ext = AB'(cy_r);
    ax     = (x_ext >= cx_ext) ? x_ext - cx_ext : cx_ext - x_ext;
    ay     = (y_ext >= cy_ext) ? y_ext - cy_ext : cy_ext - y_ext;
    sqy    = SQB'(ay) * SQB'(ay);
    r2     = (SQB + 1)'(sq_r) + (SQB + 1)'(sqy);
  end

  // square root digit step, two bits a cycle
  always_comb begin
    sq_try   = {sqrem_r, v_r[VB-1:VB-2]};
    sq_trial = {2'b00, root_r, 2'b01};
  end

  // bin = (root + 1) / 2, saturated
  always_comb begin
    k_full = ((RB + 1)'(root_r) + (RB + 1)'(1)) >> 1;
    if (32'(k_full) > PROFILE_BINS - 1) begin
      bin = BB'(PROFILE_BINS - 1);
    end else begin
      bin = BB'(k_full);
    end
  end

  assign q_push = (state_r == F_PUSH);
  assign q_data = {op_r, idx_r, bin, pix_r, last_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (take) begin
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (step_r == SW'(IB - 1)) begin
          state_nxt = F_MULX;
        end
      end
      F_MULX: state_nxt = F_MULY;
      F_MULY: state_nxt = F_SQRT;
      F_SQRT: begin
        if (step_r == SW'(RB - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      load_cnt_r  <= '0;
      drain_cnt_r <= '0;
      full_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take && !is_fetch) begin
        load_cnt_r <= load_cnt_r + CW'(1);
        if ((load_cnt_r + CW'(1)) >= size) begin
          full_r <= 1'b1;
        end
      end else if (take) begin
        if (fetch_last) begin
          full_r      <= 1'b0;
          load_cnt_r  <= '0;
          drain_cnt_r <= '0;
        end else begin
          drain_cnt_r <= drain_cnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (take) begin
          op_r   <= in_word.operation;
          pix_r  <= in_word.pixel;
          last_r <= fetch_last;
          idx_r  <= idx;
          quo_r  <= idx;
          rem_r  <= '0;
          w_r    <= eff_w;
          cx_r   <= cfg.center_x;
          cy_r   <= cfg.center_y;
          step_r <= '0;
        end
      end
      F_DIV: begin
        rem_r  <= div_rem;
        quo_r  <= div_quo;
        step_r <= (step_r == SW'(IB - 1)) ? '0 : step_r + SW'(1);
      end
      F_MULX: sq_r <= SQB'(ax) * SQB'(ax);
      F_MULY: begin
        v_r     <= {1'b0, r2, 6'd0};
        sqrem_r <= '0;
        root_r  <= '0;
      end
      F_SQRT: begin
        if (sq_try >= sq_trial) begin
          sqrem_r <= (RB + 2)'(sq_try - sq_trial);
          root_r  <= {root_r[RB-2:0], 1'b1};
        end else begin
          sqrem_r <= (RB + 2)'(sq_try);
          root_r  <= {root_r[RB-2:0], 1'b0};
        end
        v_r    <= v_r << 2;
        step_r <= (step_r == SW'(RB - 1)) ? '0 : step_r + SW'(1);
      end
      default: ;
    endcase
  end

endmodule

### hdl/rmps_back.sv
`timescale 1ns / 1ps
module rmps_back import rmps_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int PROFILE_BINS = 2048,
  parameter int IB           = 16,
  parameter int BB           = 11,
  parameter int QW           = 53
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic [QW-1:0] q_data,
  output logic          out_empty,
  input  logic          out_pop,
  output out_word_t     out_word
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS - 1){1'b1}}};

  back_state_t state_r, state_nxt;

  logic [PIXEL_BITS-1:0] frame_mem [DEPTH];
  logic [PIXEL_BITS-1:0] bin_mem [PROFILE_BINS];

  logic [QW-1:0]         cur_r;
  logic [PIXEL_BITS-1:0] fs_rd_r, bm_rd_r;
  logic [BB-1:0]         clr_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;

  logic                         cur_op, cur_last, out_free, bin_lower, is_load;
  logic [IB-1:0]                cur_idx;
  logic [BB-1:0]                cur_bin;
  logic signed [PIXEL_BITS-1:0] cur_pix;

  assign {cur_op, cur_idx, cur_bin, cur_pix, cur_last} = cur_r;

  assign is_load   = (cur_op == OP_LOAD);
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_word  = out_word_r;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign bin_lower = (cur_pix < $signed(bm_rd_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_READ;
        end
      end
      B_READ: state_nxt = B_EXEC;
      B_EXEC: begin
        if (is_load) begin
          state_nxt = B_IDLE;
        end else if (out_free) begin
          state_nxt = cur_last ? B_CLEAR : B_IDLE;
        end
      end
      B_CLEAR: begin
        if (clr_r == BB'(PROFILE_BINS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_r <= (clr_r == BB'(PROFILE_BINS - 1)) ? '0 : clr_r + BB'(1);
      end
      if (state_r == B_EXEC && !is_load && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (state_r == B_EXEC && !is_load && out_free) begin
      out_word_r.value <= PIXEL_BITS'(fs_rd_r - bm_rd_r);
      out_word_r.last  <= cur_last;
    end
  end

  // frame store and bin minima
  always_ff @(posedge clk) begin
    if (state_r == B_READ) begin
      fs_rd_r <= frame_mem[cur_idx];
      bm_rd_r <= bin_mem[cur_bin];
    end
    if (state_r == B_EXEC && is_load) begin
      frame_mem[cur_idx] <= cur_pix;
    end
    if (state_r == B_CLEAR) begin
      bin_mem[clr_r] <= PIX_MAX;
    end else if (state_r == B_EXEC && is_load && bin_lower) begin
      bin_mem[cur_bin] <= cur_pix;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLEAR |-> !q_pop) else $error("item taken during clearing pass");

  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r != '0 |-> state_r == B_CLEAR) else $error("clear counter left mid sweep");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EXEC && !is_load && out_free) |=> out_valid_r)
    else $error("fetch result lost");

  a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EXEC && !is_load && !out_free) |=> state_r == B_EXEC)
    else $error("fetch left exec while output held");

endmodule

### hdl/radial_min_profile_subtract.sv
`timescale 1ns / 1ps
// radial minimum profile background subtraction
// input channel: push a word when full is low; operation 0 loads a pixel in
// raster order, operation 1 fetches the next background-subtracted pixel.
// loads after a full frame and fetches before the frame is full are dropped.
// result channel: a word waits on out_word while out_empty is low and leaves
// on out_pop; last marks the final pixel of the frame.
// config port: cfg_we writes cfg_data to register cfg_index at once; write
// only while no word is in flight.
// each accepted word holds the front busy (in_full high) through the bit-serial
// column divide (one bit a cycle over the store index width IB) and the
// bit-serial root (RB steps, 20 at default size); the back then steps each
// word through its idle, read and exec states for its registered memory
// reads.
// reset and the last fetch of each frame start a clearing pass over all
// PROFILE_BINS bin minima; words still queue up during it.
// a stalled result blocks the back only; the front keeps taking words until
// the four-entry queue between them fills.
module radial_min_profile_subtract import rmps_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int PROFILE_BINS = 2048
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  in_word_t                 in_word,
  output logic                     out_empty,
  input  logic                     out_pop,
  output out_word_t                out_word,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int IB = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int BB = $clog2(PROFILE_BINS);
  localparam int QW = 1 + IB + BB + PIXEL_BITS + 1;

  cfg_regs_t     cfg_r;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= CFG_SIZE_BITS'(256);
      cfg_r.image_height <= CFG_SIZE_BITS'(256);
      cfg_r.center_x     <= CFG_CENTER_BITS'(128);
      cfg_r.center_y     <= CFG_CENTER_BITS'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        CFG_CENTER_X:     cfg_r.center_x     <= cfg_data[CFG_CENTER_BITS-1:0];
        CFG_CENTER_Y:     cfg_r.center_y     <= cfg_data[CFG_CENTER_BITS-1:0];
        default: ;
      endcase
    end
  end

  rmps_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PROFILE_BINS(PROFILE_BINS),
    .IB(IB), .BB(BB), .QW(QW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .cfg(cfg_r),
    .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
  );

  rmps_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .full(q_full), .wdata(q_wdata),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  rmps_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PROFILE_BINS(PROFILE_BINS),
    .IB(IB), .BB(BB), .QW(QW)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import rmps_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int CFG_SETTLE = 2600;

  typedef struct {
    logic            op;
    logic [23:0]     pix;
    bit              typed;
    logic [23:0]     val;
    logic            lst;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  in_word_t   in_word = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  radial_min_profile_subtract uut (.*);

  always #5 clk = ~clk;

  // predictor state
  int          pix_store [65536];
  int          bin_floor [2048];
  int unsigned loaded, drained;
  bit          frame_done;
  int unsigned reg_w, reg_h, reg_cx, reg_cy;

  out_word_t   pending_results [$];
  int          errors = 0;
  int          results_seen = 0;
  int          pushed_items = 0;
  int          quiet_cycles = 0;
  bit          stim_done = 1'b0;

  function automatic void clear_floors();
    foreach (bin_floor[i]) bin_floor[i] = 8388607;
  endfunction

  function automatic int unsigned eff_w();
    return reg_w < 1 ? 1 : (reg_w > 256 ? 256 : reg_w);
  endfunction

  function automatic int unsigned eff_h();
    return reg_h < 1 ? 1 : (reg_h > 256 ? 256 : reg_h);
  endfunction

  function automatic int unsigned radial_bin(int unsigned idx);
    longint dx, dy, r2, root;
    longint k;
    dx = longint'(idx % eff_w()) - longint'(reg_cx);
    dy = longint'(idx / eff_w()) - longint'(reg_cy);
    r2 = (dx * dx + dy * dy) * 64;
    root = 0;
    while ((root + 1) * (root + 1) <= r2) root++;
    k = (root + 1) >> 1;
    if (k > 2047) k = 2047;
    return int'(k);
  endfunction

  // returns 1 when the word produces a result
  function automatic bit subtract_step(in_word_t w, output out_word_t r);
    int unsigned size, idx, b;
    int p;
    size = eff_w() * eff_h();
    r = '0;
    if (w.operation == OP_LOAD) begin
      if (frame_done) return 1'b0;
      idx = loaded > 65535 ? 65535 : loaded;
      p = $signed(w.pixel);
      pix_store[idx] = p;
      b = radial_bin(idx);
      if (p < bin_floor[b]) bin_floor[b] = p;
      loaded++;
      if (loaded >= size) frame_done = 1'b1;
      return 1'b0;
    end
    if (!frame_done) return 1'b0;
    idx = drained > 65535 ? 65535 : drained;
    b = radial_bin(idx);
    r.value = 24'(pix_store[idx] - bin_floor[b]);
    r.last = (drained + 1 >= size);
    drained++;
    if (r.last) begin
      frame_done = 1'b0;
      loaded = 0;
      drained = 0;
      clear_floors();
    end
    return 1'b1;
  endfunction

  function automatic bit sender_idle();
    if (pushed_items >= 300 && pushed_items < 500) return 1'b0;
    return $urandom_range(99) < 11;
  endfunction

  // drives one word; returns at the falling edge after it was taken
  task automatic push_word(in_word_t w, bit typed, out_word_t typed_res);
    bit was_full;
    bit has_res;
    out_word_t r;
    while (sender_idle()) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    do begin
      #1 was_full = in_full;
      @(negedge clk);
    end while (was_full);
    has_res = subtract_step(w, r);
    if (has_res) pending_results.push_back(typed ? typed_res : r);
    pushed_items++;
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(data);
    @(negedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  reg_w = data & 9'h1ff;
      CFG_IMAGE_HEIGHT: reg_h = data & 9'h1ff;
      CFG_CENTER_X:     reg_cx = data & 8'hff;
      default:          reg_cy = data & 8'hff;
    endcase
  endtask

  task automatic setup_frame(int unsigned w, int unsigned h, int unsigned cx, int unsigned cy);
    in_push <= 1'b0;
    @(negedge clk);
    wait (pending_results.size() == 0);
    repeat (CFG_SETTLE) @(negedge clk);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(7))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(15));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_frame();
    int unsigned n, i;
    in_word_t w;
    n = eff_w() * eff_h();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        w.operation = OP_FETCH;
        w.pixel = random_pixel();
        push_word(w, 1'b0, '0);
      end
      w.operation = OP_LOAD;
      w.pixel = random_pixel();
      push_word(w, 1'b0, '0);
    end
    for (i = 0; i < n; i++) begin
      if (i < n - 1 && $urandom_range(9) == 0) begin
        w.operation = OP_LOAD;
        w.pixel = random_pixel();
        push_word(w, 1'b0, '0);
      end
      w.operation = OP_FETCH;
      w.pixel = random_pixel();
      push_word(w, 1'b0, '0);
    end
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected word value=%0h last=%0b", out_word.value, out_word.last);
        errors++;
      end else begin
        if (out_word.value !== pending_results[0].value) begin
          $error("value expected %0h actual %0h", pending_results[0].value, out_word.value);
          errors++;
        end
        if (out_word.last !== pending_results[0].last) begin
          $error("last expected %0b actual %0b", pending_results[0].last, out_word.last);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // receiver
  initial begin
    int unsigned pops;
    bit held;
    pops = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (results_seen >= 200 && results_seen < 350) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= ($urandom_range(99) >= 11);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    in_word_t w;
    out_word_t r;
    int i;
    reg_w = 256; reg_h = 256; reg_cx = 128; reg_cy = 128;
    loaded = 0; drained = 0; frame_done = 1'b0;
    clear_floors();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 2x2 frame around the corner: bins 0, 4, 4, 6
    rows = '{
      '{OP_FETCH, 24'h000000, 1'b0, 24'h0, 1'b0},
      '{OP_LOAD,  24'h7fffff, 1'b0, 24'h0, 1'b0},
      '{OP_LOAD,  24'h800000, 1'b0, 24'h0, 1'b0},
      '{OP_FETCH, 24'h000000, 1'b0, 24'h0, 1'b0},
      '{OP_LOAD,  24'h000005, 1'b0, 24'h0, 1'b0},
      '{OP_LOAD,  24'h800000, 1'b0, 24'h0, 1'b0},
      '{OP_LOAD,  24'h123456, 1'b0, 24'h0, 1'b0},
      '{OP_FETCH, 24'h000000, 1'b1, 24'h000000, 1'b0},
      '{OP_FETCH, 24'h000000, 1'b1, 24'h000000, 1'b0},
      '{OP_FETCH, 24'h000000, 1'b1, 24'h800005, 1'b0},
      '{OP_FETCH, 24'h000000, 1'b1, 24'h000000, 1'b1},
      '{OP_FETCH, 24'h000000, 1'b0, 24'h0, 1'b0},
      '{OP_LOAD,  24'h000042, 1'b0, 24'h0, 1'b0},
      '{OP_FETCH, 24'h000000, 1'b1, 24'h000000, 1'b1}
    };
    setup_frame(2, 2, 0, 0);
    for (i = 0; i < rows.size(); i++) begin
      if (i == 12) setup_frame(0, 0, 255, 255);
      w.operation = rows[i].op;
      w.pixel = rows[i].pix;
      r.value = rows[i].val;
      r.last = rows[i].lst;
      push_word(w, rows[i].typed, r);
    end

    setup_frame(511, 1, 255, 255);
    run_frame();
    setup_frame(1, 40, 0, 255);
    run_frame();
    while (pushed_items < 750) begin
      setup_frame($urandom_range(9) == 0 ? $urandom_range(16) : $urandom_range(1, 8),
                  $urandom_range(9) == 0 ? $urandom_range(16) : $urandom_range(1, 8),
                  $urandom_range(255), $urandom_range(255));
      run_frame();
    end

    in_push <= 1'b0;
    stim_done = 1'b1;
    wait (pending_results.size() == 0);
    repeat (200) @(negedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

### radial_min_profile_subtract.f
hdl/rmps_pkg.sv
hdl/rmps_queue.sv
hdl/rmps_front.sv
hdl/rmps_back.sv
hdl/radial_min_profile_subtract.sv
verif/tb.sv
